// ===== sv/permutation_rank_unit_macros.svh =====
// Assertion macros shared by the permutation rank unit's modules.
`ifndef PERMUTATION_RANK_UNIT_MACROS_SVH
`define PERMUTATION_RANK_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PRANK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRANK_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PRANK_ASSERT(label, clk, rst, prop, msg)
`define PRANK_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== sv/prank_pkg.sv =====
// Types and constants of the permutation rank unit.
`default_nettype none
package prank_pkg;

   localparam int ELEMENT_W  = 16;
   localparam int RANK_W     = 45;
   localparam int FACT_IDX_W = 4;

   localparam logic [RANK_W-1:0] FACT_TABLE [2**FACT_IDX_W] = '{
      45'd1, 45'd1, 45'd2, 45'd6, 45'd24, 45'd120, 45'd720, 45'd5040,
      45'd40320, 45'd362880, 45'd3628800, 45'd39916800, 45'd479001600,
      45'd6227020800, 45'd87178291200, 45'd1307674368000
   };

   typedef struct packed {
      logic load;     // item accepted this cycle
      logic step;     // one position of the ranking walk
      logic publish;  // move the rank to the output register, clear sequence
   } prank_cmd_type;

   typedef struct packed {
      logic overflow;   // store full or already overflowed
      logic walk_more;  // positions left in the walk
      logic out_free;   // output register can take a result
   } prank_status_type;

endpackage
`default_nettype wire

// ===== sv/prank_if.sv =====
// Valid/ready channel interfaces for elements in and ranks out.
`default_nettype none
interface prank_req_if;
   import prank_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ELEMENT_W-1:0] element;
   logic                 last;

   modport source (output valid, output element, output last, input ready);
   modport sink   (input valid, input element, input last, output ready);
endinterface

interface prank_rsp_if;
   import prank_pkg::*;

   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank;
   logic              length_error;

   modport source (output valid, output rank, output length_error, input ready);
   modport sink   (input valid, input rank, input length_error, output ready);
endinterface
`default_nettype wire

// ===== sv/prank_datapath.sv =====
// Element store, smaller-count lanes, weighted accumulator and output register.
`default_nettype none
`include "permutation_rank_unit_macros.svh"
module prank_datapath #(
   parameter int MAX_LEN   = 16,
   parameter int ELEM_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prank_pkg::prank_cmd_type            cmd,
   input  logic [prank_pkg::ELEMENT_W-1:0]     req_element,
   input  logic                                rsp_ready,
   output prank_pkg::prank_status_type         status,
   output logic                                rsp_valid,
   output logic [prank_pkg::RANK_W-1:0]        rsp_rank,
   output logic                                rsp_length_error
);
   import prank_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = $clog2(MAX_LEN);

   logic [ELEM_BITS-1:0]  store_ff [MAX_LEN];
   logic [ELEM_BITS-1:0]  store_in [MAX_LEN];
   logic [IDX_W-1:0]      cnt_ff   [MAX_LEN];
   logic [IDX_W-1:0]      cnt_in   [MAX_LEN];
   logic [LEN_W-1:0]      fill_ff, fill_in;
   logic [LEN_W-1:0]      walk_ff, walk_in;
   logic                  ovf_ff, ovf_in;
   logic [RANK_W-1:0]     prod_ff, prod_in;
   logic                  prod_valid_ff, prod_valid_in;
   logic [RANK_W-1:0]     acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RANK_W-1:0]     out_rank_ff, out_rank_in;
   logic                  out_err_ff, out_err_in;

   logic [ELEM_BITS-1:0]  value;
   logic                  full;
   logic [FACT_IDX_W-1:0] fact_idx;

   assign value    = ELEM_BITS'(req_element);
   assign full     = (fill_ff == LEN_W'(MAX_LEN));
   // weight index is the number of positions after the current one
   assign fact_idx = FACT_IDX_W'(fill_ff - walk_ff - LEN_W'(1));

   assign status.overflow  = ovf_ff | full;
   assign status.walk_more = (walk_ff + LEN_W'(1)) < fill_ff;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      store_in      = store_ff;
      cnt_in        = cnt_ff;
      fill_in       = fill_ff;
      ovf_in        = ovf_ff;
      walk_in       = walk_ff;
      prod_in       = prod_ff;
      prod_valid_in = 1'b0;
      acc_in        = acc_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_rank_in   = out_rank_ff;
      out_err_in    = out_err_ff;

      if (cmd.load) begin
         // every stored lane counts the later elements below it
         for (int i = 0; i < MAX_LEN; i++) begin
            if (LEN_W'(i) < fill_ff && value < store_ff[i]) begin
               cnt_in[i] = cnt_ff[i] + 1'b1;
            end
         end
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            store_in[fill_ff[IDX_W-1:0]] = value;
            cnt_in[fill_ff[IDX_W-1:0]]   = '0;
            fill_in                      = fill_ff + LEN_W'(1);
         end
      end

      if (cmd.step) begin
         prod_in       = RANK_W'(FACT_TABLE[fact_idx] * RANK_W'(cnt_ff[walk_ff[IDX_W-1:0]]));
         prod_valid_in = 1'b1;
         walk_in       = walk_ff + LEN_W'(1);
      end

      if (prod_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end

      if (cmd.publish) begin
         out_valid_in = 1'b1;
         out_rank_in  = ovf_ff ? '0 : acc_ff;
         out_err_in   = ovf_ff;
         fill_in      = '0;
         ovf_in       = 1'b0;
         walk_in      = '0;
         acc_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         walk_ff       <= '0;
         ovf_ff        <= 1'b0;
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         walk_ff       <= walk_in;
         ovf_ff        <= ovf_in;
         prod_valid_ff <= prod_valid_in;
         acc_ff        <= acc_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff    <= store_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      out_rank_ff <= out_rank_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_rank         = out_rank_ff;
   assign rsp_length_error = out_err_ff;

   `PRANK_ASSERT(a_fill_bound, clock, reset, fill_ff <= LEN_W'(MAX_LEN), "fill count past store")
   `PRANK_ASSERT_NEVER(a_publish_drained, clock, reset, cmd.publish && prod_valid_ff, "rank published before walk drained")
   `PRANK_ASSERT(a_error_rank_zero, clock, reset, (out_valid_ff && out_err_ff) |-> (out_rank_ff == '0), "length error with non-zero rank")

endmodule
`default_nettype wire

// ===== sv/prank_ctrl.sv =====
// Sequencer for loading, the ranking walk and result hand-off.
`default_nettype none
`include "permutation_rank_unit_macros.svh"
module prank_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_last,
   input  prank_pkg::prank_status_type status,
   output logic                        req_ready,
   output prank_pkg::prank_cmd_type    cmd
);
   import prank_pkg::*;

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // an overlong sequence skips the walk and reports rank 0
               if (req_last) begin
                  state_in = status.overflow ? ST_FINISH : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (status.walk_more) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_LOAD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   `PRANK_ASSERT(a_finish_entry, clock, reset, (state_ff == ST_FINISH) |-> ($past(state_ff) == ST_FINISH || $past(state_ff) == ST_DRAIN || $past(state_ff) == ST_LOAD), "finish entered mid-walk")

endmodule
`default_nettype wire

// ===== sv/permutation_rank_unit.sv =====
// Top level of the permutation rank unit.
// Elements of a sequence are taken one per cycle until the item marked last;
// each stored element keeps a running count of later, smaller elements.
// After the last element a walk multiplies each count by the factorial of
// the positions that follow, one position per cycle through a registered
// multiplier and a 45-bit accumulator; no element is taken during the walk.
// The rank then sits in an output register, and loading of the next
// sequence goes on while it waits. A sequence longer than MAX_LEN gives
// rank 0 with length_error set; element bits above ELEM_BITS are ignored.
`default_nettype none
module permutation_rank_unit #(
   parameter int MAX_LEN   = 16,
   parameter int ELEM_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   prank_req_if.sink  req_if,
   prank_rsp_if.source rsp_if
);
   import prank_pkg::*;

   prank_cmd_type    cmd;
   prank_status_type status;

   prank_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last),
      .status    (status),
      .req_ready (req_if.ready),
      .cmd       (cmd)
   );

   prank_datapath #(
      .MAX_LEN   (MAX_LEN),
      .ELEM_BITS (ELEM_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_element      (req_if.element),
      .rsp_ready        (rsp_if.ready),
      .status           (status),
      .rsp_valid        (rsp_if.valid),
      .rsp_rank         (rsp_if.rank),
      .rsp_length_error (rsp_if.length_error)
   );

endmodule
`default_nettype wire

// ===== bench/prank_rank_checker.sv =====
`timescale 1ns / 100ps
// Checker for the permutation rank unit: predicts each sequence's rank and compares result items.
module prank_rank_checker #(
   parameter int MAX_LEN   = 16,
   parameter int ELEM_BITS = 16
) (
   input  logic  clock,
   input  logic  reset,
   prank_req_if  req_mon,
   prank_rsp_if  rsp_mon,
   output int    error_count,
   output int    pending_ranks
);
   import prank_pkg::*;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              length_error;
   } rank_item_type;

   localparam logic [ELEMENT_W-1:0] ELEM_MASK = ELEMENT_W'((64'd1 << ELEM_BITS) - 64'd1);

   logic [ELEMENT_W-1:0] seq_store [MAX_LEN];
   int unsigned          seq_fill = 0;
   bit                   seq_overflow = 0;
   rank_item_type        expected_ranks [$];
   int                   errors = 0;

   // Lehmer code: later smaller elements at each position, weighted by (n-1-i)!
   function automatic logic [RANK_W-1:0] lehmer_rank(input int unsigned n);
      logic [RANK_W-1:0] sum;
      logic [RANK_W-1:0] weight;
      int unsigned       smaller;
      sum = '0;
      for (int unsigned i = 0; i + 1 < n; i++) begin
         smaller = 0;
         for (int unsigned j = i + 1; j < n; j++)
            if (seq_store[j] < seq_store[i]) smaller++;
         weight = 1;
         for (int unsigned k = 2; k <= n - 1 - i; k++) weight = weight * k;
         sum = sum + smaller * weight;
      end
      return sum;
   endfunction

   always @(posedge clock) begin : monitor
      rank_item_type want;
      if (reset) begin
         seq_fill     = 0;
         seq_overflow = 0;
         expected_ranks.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (seq_fill < MAX_LEN) begin
               seq_store[seq_fill] = req_mon.element & ELEM_MASK;
               seq_fill++;
            end else begin
               seq_overflow = 1;
            end
            if (req_mon.last) begin
               want.length_error = seq_overflow;
               want.rank         = seq_overflow ? '0 : lehmer_rank(seq_fill);
               expected_ranks.push_back(want);
               seq_fill     = 0;
               seq_overflow = 0;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_ranks.size() == 0) begin
               $display("%0t: unexpected rank item: rank %0d length_error %0b",
                        $time, rsp_mon.rank, rsp_mon.length_error);
               errors++;
            end else begin
               want = expected_ranks.pop_front();
               if (rsp_mon.rank !== want.rank) begin
                  $display("%0t: rank mismatch: expected %0d actual %0d",
                           $time, want.rank, rsp_mon.rank);
                  errors++;
               end
               if (rsp_mon.length_error !== want.length_error) begin
                  $display("%0t: length_error mismatch: expected %0b actual %0b",
                           $time, want.length_error, rsp_mon.length_error);
                  errors++;
               end
            end
         end
      end
      error_count   <= errors;
      pending_ranks <= expected_ranks.size();
   end

endmodule

// ===== bench/tb_permutation_rank_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the permutation rank unit: element stimulus, result-side stalls and verdict.
module tb_permutation_rank_unit;
   import prank_pkg::*;

   localparam int MAX_LEN     = 16;
   localparam int ELEM_BITS   = 16;
   localparam int ITEM_TARGET = 1900;

   typedef enum int {
      FILL_RANDOM,
      FILL_FEW_VALUES,
      FILL_PERMUTATION,
      FILL_EXTREMES
   } fill_style_type;

   typedef logic [ELEMENT_W-1:0] element_type;

   logic clock = 1'b0;
   logic reset;
   int   check_errors;
   int   pending_ranks;
   int   items_sent = 0;

   prank_req_if req_ch ();
   prank_rsp_if rsp_ch ();

   permutation_rank_unit #(
      .MAX_LEN   (MAX_LEN),
      .ELEM_BITS (ELEM_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   prank_rank_checker #(
      .MAX_LEN   (MAX_LEN),
      .ELEM_BITS (ELEM_BITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (check_errors),
      .pending_ranks (pending_ranks)
   );

   always #10 clock = ~clock;

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stalls, one long hold-off to back the unit up, one calm stretch.
   initial begin : rsp_side
      int cycle;
      cycle = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle >= 1500 && cycle < 1800) begin
            rsp_ch.ready <= 1'b0;
         end else if (cycle >= 2500 && cycle < 3500) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 17);
         end
      end
   end

   task automatic send_element(input element_type value, input logic is_last);
      int gap;
      bit calm;
      calm = (items_sent >= 700 && items_sent < 1000);
      if (!calm && $urandom_range(99) < 17) begin
         gap = $urandom_range(4, 1);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.element <= value;
      req_ch.last    <= is_last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_sequence(input element_type seq_vals [$]);
      foreach (seq_vals[i]) send_element(seq_vals[i], i == seq_vals.size() - 1);
   endtask

   task automatic wait_drained(input int limit);
      int waited;
      waited = 0;
      @(posedge clock);
      while (pending_ranks != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   initial begin : stimulus
      element_type    seq_vals [$];
      element_type    swap;
      fill_style_type style;
      int             len;
      int             pick;
      int             seq_index;
      bit             drained_once;
      seq_index    = 0;
      drained_once = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.element <= '0;
      req_ch.last    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single element, field extremes, equal elements, longest descending run
      seq_vals = {16'hFFFF};
      send_sequence(seq_vals);
      seq_vals = {16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
      send_sequence(seq_vals);
      seq_vals = {16'h0007, 16'h0007, 16'h0007};
      send_sequence(seq_vals);
      seq_vals = {};
      for (int i = 0; i < MAX_LEN; i++) seq_vals.push_back(16'hFFFF - element_type'(i));
      send_sequence(seq_vals);

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (seq_index == 0)      len = MAX_LEN + 1;
         else if (seq_index == 1) len = MAX_LEN + 4;
         else if (pick < 8)       len = $urandom_range(MAX_LEN + 4, MAX_LEN + 1);
         else if (pick < 16)      len = MAX_LEN;
         else if (pick < 50)      len = $urandom_range(4, 1);
         else                     len = $urandom_range(MAX_LEN - 1, 5);
         style = fill_style_type'($urandom_range(3));
         seq_vals = {};
         for (int i = 0; i < len; i++) begin
            unique case (style)
               FILL_RANDOM:      seq_vals.push_back(element_type'($urandom));
               FILL_FEW_VALUES:  seq_vals.push_back(element_type'($urandom_range(3)));
               FILL_PERMUTATION: seq_vals.push_back(element_type'(i));
               FILL_EXTREMES: begin
                  if ($urandom_range(1))
                     seq_vals.push_back(16'hFFFF - element_type'($urandom_range(2)));
                  else
                     seq_vals.push_back(element_type'($urandom_range(2)));
               end
            endcase
         end
         if (style == FILL_PERMUTATION) begin
            for (int i = len - 1; i > 0; i--) begin
               pick        = $urandom_range(i);
               swap        = seq_vals[i];
               seq_vals[i] = seq_vals[pick];
               seq_vals[pick] = swap;
            end
         end
         send_sequence(seq_vals);
         seq_index++;
         // once, let the sender go quiet until every rank has come back
         if (!drained_once && items_sent >= 1300) begin
            req_ch.valid <= 1'b0;
            wait_drained(20000);
            drained_once = 1;
         end
      end

      req_ch.valid <= 1'b0;
      wait_drained(20000);
      repeat (40) @(posedge clock);
      if (check_errors == 0 && pending_ranks == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
